>>> design/umdt_pkg.sv
package umdt_pkg;

    localparam int CELLS     = 65536;
    localparam int SLOTS     = 9;
    localparam int CELL_AW   = $clog2(CELLS);
    localparam int NB_DEPTH  = CELLS * SLOTS;
    localparam int NB_AW     = $clog2(NB_DEPTH);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NO_DATA   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = CFG_IDX_W'(1);

    localparam logic signed [31:0] NO_DATA_RESET   = -32'sd9999;
    localparam logic [15:0]        MAX_STEPS_RESET = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_WR_NB  = 2'd0,
        CMD_WR_DIS = 2'd1,
        CMD_WR_GID = 2'd2,
        CMD_TRACE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        cell_req;
        logic [3:0]         slot;
        logic [15:0]        neighbor_cell;
        logic [31:0]        discharge_value;
        logic signed [31:0] global_value;
    } t_item;

    typedef struct packed {
        logic [15:0]        source_cell;
        logic signed [31:0] source_global_id;
        logic               id_found;
        logic               step_limit_hit;
    } t_result;

    typedef struct packed {
        logic               item_wr;
        logic               load;
        logic               base;
        logic               issue;
        logic [3:0]         slot;
        logic               move;
        logic               limit;
        logic               lookup;
        logic               emit;
        logic               clr_wr;
        logic [CELL_AW-1:0] clr_addr;
    } t_ctl;

    typedef struct packed {
        logic cur_ok;
        logic moves;
        logic at_limit;
    } t_sts;

    function automatic logic cell_ok(input logic [15:0] c);
        return (c != 16'd0) && (int'(c) <= CELLS);
    endfunction

endpackage

>>> design/umdt_ctrl.sv
module umdt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_command,
    input  umdt_pkg::t_sts i_sts,
    output umdt_pkg::t_ctl o_ctl,
    output logic           o_busy
);
    import umdt_pkg::*;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_BASE   = 8'b0000_0100,
        ST_SCAN   = 8'b0000_1000,
        ST_DRAIN  = 8'b0001_0000,
        ST_DECIDE = 8'b0010_0000,
        ST_LOOKUP = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CELL_AW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        o_ctl.slot     = r_cnt[3:0];
        o_ctl.clr_addr = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                o_ctl.clr_wr = 1'b1;
                n_cnt        = r_cnt + CELL_AW'(1);
                if (r_cnt == CELL_AW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    if (i_command == CMD_TRACE) begin
                        o_ctl.load = 1'b1;
                        n_state    = ST_BASE;
                    end else begin
                        o_ctl.item_wr = 1'b1;
                    end
                end
            end
            ST_BASE: begin
                if (!i_sts.cur_ok) begin
                    n_state = ST_LOOKUP;
                end else begin
                    o_ctl.base = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_ctl.issue = 1'b1;
                n_cnt       = r_cnt + CELL_AW'(1);
                if (r_cnt == CELL_AW'(SLOTS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + CELL_AW'(1);
                if (r_cnt == CELL_AW'(1)) begin
                    n_cnt   = '0;
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!i_sts.moves) begin
                    n_state = ST_LOOKUP;
                end else if (i_sts.at_limit) begin
                    o_ctl.limit = 1'b1;
                    n_state     = ST_LOOKUP;
                end else begin
                    o_ctl.move = 1'b1;
                    n_state    = ST_BASE;
                end
            end
            ST_LOOKUP: begin
                o_ctl.lookup = 1'b1;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                o_ctl.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> design/umdt_dp.sv
module umdt_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  umdt_pkg::t_item                i_item,
    input  logic                           i_cfg_we,
    input  logic [umdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [umdt_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  umdt_pkg::t_ctl                 i_ctl,
    output umdt_pkg::t_sts                 o_sts,
    output logic                           o_result_valid,
    output umdt_pkg::t_result              o_result
);
    import umdt_pkg::*;

    logic [15:0] r_nb_mem  [NB_DEPTH];
    logic [31:0] r_dis_mem [CELLS];
    logic [31:0] r_gid_mem [CELLS];
    logic        r_gv_mem  [CELLS];

    logic signed [31:0] r_no_data;
    logic [15:0]        r_max_steps;

    logic [15:0]        r_cur;
    logic [15:0]        r_steps;
    logic               r_hit;
    logic [NB_AW-1:0]   r_base;
    logic               r_v1, r_v2;
    logic [15:0]        r_nb_rd;
    logic [15:0]        r_n2;
    logic [31:0]        r_dis_rd;
    logic [1:0]         r_count;
    logic [15:0]        r_only;
    logic [15:0]        r_best;
    logic [31:0]        r_best_dis;
    logic [31:0]        r_gid_rd;
    logic               r_gv_rd;
    logic               r_out_valid;
    t_result            r_result;

    logic [15:0]        w_in_cm1;
    logic [NB_AW-1:0]   w_nb_wr_addr;
    logic               w_in_ok;
    logic [15:0]        w_cur_cm1;
    logic [15:0]        w_nxt;
    logic [31:0]        w_d;
    logic               w_found;

    always_comb begin
        w_in_cm1     = i_item.cell_req - 16'd1;
        w_nb_wr_addr = (NB_AW'(w_in_cm1) << 3) + NB_AW'(w_in_cm1) + NB_AW'(i_item.slot);
        w_in_ok      = cell_ok(i_item.cell_req);
        w_cur_cm1    = r_cur - 16'd1;
        w_d          = cell_ok(r_n2) ? r_dis_rd : 32'd0;
        if (r_count == 2'd0) begin
            w_nxt = r_cur;
        end else if (r_count == 2'd1) begin
            w_nxt = r_only;
        end else if (r_best == 16'd0) begin
            w_nxt = r_cur;
        end else begin
            w_nxt = r_best;
        end
        o_sts.cur_ok   = cell_ok(r_cur);
        o_sts.moves    = (w_nxt != r_cur);
        o_sts.at_limit = (r_steps >= r_max_steps);
        w_found        = cell_ok(r_cur) && r_gv_rd;
    end

    // neighbor slots
    always_ff @(posedge i_clk) begin
        if (i_ctl.item_wr && i_item.command == CMD_WR_NB && w_in_ok
                && i_item.slot < 4'(SLOTS)) begin
            r_nb_mem[w_nb_wr_addr] <= i_item.neighbor_cell;
        end
        if (i_ctl.issue) begin
            r_nb_rd <= r_nb_mem[r_base + NB_AW'(i_ctl.slot)];
        end
    end

    // discharge
    always_ff @(posedge i_clk) begin
        if (i_ctl.item_wr && i_item.command == CMD_WR_DIS && w_in_ok) begin
            r_dis_mem[CELL_AW'(w_in_cm1)] <= i_item.discharge_value;
        end
        if (r_v1) begin
            r_dis_rd <= r_dis_mem[CELL_AW'(r_nb_rd - 16'd1)];
        end
    end

    // global id
    always_ff @(posedge i_clk) begin
        if (i_ctl.item_wr && i_item.command == CMD_WR_GID && w_in_ok) begin
            r_gid_mem[CELL_AW'(w_in_cm1)] <= i_item.global_value;
        end
        if (i_ctl.lookup) begin
            r_gid_rd <= r_gid_mem[CELL_AW'(w_cur_cm1)];
        end
    end

    // id valid flags, swept clear after reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_wr) begin
            r_gv_mem[i_ctl.clr_addr] <= 1'b0;
        end else if (i_ctl.item_wr && i_item.command == CMD_WR_GID && w_in_ok) begin
            r_gv_mem[CELL_AW'(w_in_cm1)] <= 1'b1;
        end
        if (i_ctl.lookup) begin
            r_gv_rd <= r_gv_mem[CELL_AW'(w_cur_cm1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_data   <= NO_DATA_RESET;
            r_max_steps <= MAX_STEPS_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NO_DATA:   r_no_data   <= i_cfg_wdata;
                    REG_MAX_STEPS: r_max_steps <= i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            r_v1        <= i_ctl.issue;
            r_v2        <= r_v1;
            r_out_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cur   <= i_item.cell_req;
            r_steps <= 16'd0;
            r_hit   <= 1'b0;
        end else if (i_ctl.move) begin
            r_cur   <= w_nxt;
            r_steps <= r_steps + 16'd1;
        end else if (i_ctl.limit) begin
            r_hit <= 1'b1;
        end
        if (i_ctl.base) begin
            r_base <= (NB_AW'(w_cur_cm1) << 3) + NB_AW'(w_cur_cm1);
        end
        r_n2 <= r_nb_rd;
        if (i_ctl.base) begin
            r_count    <= 2'd0;
            r_only     <= 16'd0;
            r_best     <= 16'd0;
            r_best_dis <= 32'd0;
        end else begin
            if (r_v1 && r_nb_rd != 16'd0) begin
                r_only <= r_nb_rd;
                if (r_count != 2'd2) begin
                    r_count <= r_count + 2'd1;
                end
            end
            if (r_v2 && w_d > r_best_dis) begin
                r_best     <= r_n2;
                r_best_dis <= w_d;
            end
        end
        if (i_ctl.emit) begin
            r_result.source_cell      <= r_cur;
            r_result.source_global_id <= w_found ? r_gid_rd : r_no_data;
            r_result.id_found         <= w_found;
            r_result.step_limit_hit   <= r_hit;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

endmodule

>>> design/upstream_max_discharge_trace_top.sv
// channel   direction  handshake                   payload
// item      in         start & !busy               i_item (t_item)
// result    out        o_result_valid, one cycle   o_result (t_result)
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// write commands are done while idle; busy stays low after them
// a trace visits cells one at a time: for each cell a base step, nine slot
// reads from the neighbor memory port, a drain through the discharge memory
// pipeline and a decision step; then the id lookup and the result strobe
// follow, and a trace from cell zero skips the walk
// after reset a sweep clears the id valid flags of 65536 cells, busy high
// the result is held for one cycle only; the receiver cannot stall
module upstream_max_discharge_trace_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  umdt_pkg::t_item                i_item,
    input  logic                           i_cfg_we,
    input  logic [umdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [umdt_pkg::CFG_W-1:0]     i_cfg_wdata,
    output logic                           o_result_valid,
    output umdt_pkg::t_result              o_result
);
    import umdt_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;

    umdt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_sts     (w_sts),
        .o_ctl     (w_ctl),
        .o_busy    (busy)
    );

    umdt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_ctl          (w_ctl),
        .o_sts          (w_sts),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

>>> design/umdt_checker.sv
module umdt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input umdt_pkg::t_item   i_item,
    input logic              o_result_valid,
    input umdt_pkg::t_result o_result
);
    import umdt_pkg::*;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    a_trace_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.command == CMD_TRACE) |=> busy)
        else $error("trace accepted but block not busy");

    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.command != CMD_TRACE) |=> (!busy && !o_result_valid))
        else $error("write command caused busy or a result");

    a_found_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.id_found) |-> (o_result.source_cell != 16'd0))
        else $error("id found for cell zero");

endmodule

bind upstream_max_discharge_trace_top umdt_checker u_umdt_checker (.*);

>>> sim/umdt_checker.sv
module umdt_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  umdt_pkg::t_item                i_item,
    input  logic                           i_cfg_we,
    input  logic [umdt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [umdt_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_result_valid,
    input  umdt_pkg::t_result              i_result,
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import umdt_pkg::*;

    logic [15:0]        inflow[int];
    logic [31:0]        discharge[int];
    logic signed [31:0] gid[int];
    bit                 mapped[int];
    logic signed [31:0] no_data;
    logic [15:0]        step_cap;
    t_result            pending_sources[$];
    int                 errors = 0;

    assign o_errors = errors;

    function automatic bit on_grid(logic [15:0] c);
        return (c != 16'd0) && (int'(c) <= CELLS);
    endfunction

    function automatic logic [15:0] inflow_at(logic [15:0] c, int j);
        int key;
        key = (int'(c) - 1) * SLOTS + j;
        return inflow.exists(key) ? inflow[key] : 16'd0;
    endfunction

    // next cell upstream, or c itself at a source
    function automatic logic [15:0] upstream(logic [15:0] c);
        int          n_in;
        logic [15:0] nb;
        logic [15:0] only;
        logic [15:0] best;
        logic [31:0] best_q;
        logic [31:0] q;
        n_in   = 0;
        only   = 16'd0;
        best   = 16'd0;
        best_q = 32'd0;
        if (!on_grid(c)) return c;
        for (int j = 0; j < SLOTS; j++) begin
            nb = inflow_at(c, j);
            if (nb != 16'd0) begin
                n_in++;
                only = nb;
            end
        end
        if (n_in == 0) return c;
        if (n_in == 1) return only;
        for (int j = 0; j < SLOTS; j++) begin
            nb = inflow_at(c, j);
            q  = 32'd0;
            if (on_grid(nb) && discharge.exists(int'(nb))) q = discharge[int'(nb)];
            if (q > best_q) begin
                best_q = q;
                best   = nb;
            end
        end
        return (best == 16'd0) ? c : best;
    endfunction

    function automatic t_result trace_source(logic [15:0] from);
        logic [15:0] cur;
        logic [15:0] nxt;
        int          moves;
        t_result     r;
        cur   = from;
        moves = 0;
        r     = '0;
        while (1) begin
            nxt = upstream(cur);
            if (nxt == cur) break;
            if (moves >= int'(step_cap)) begin
                r.step_limit_hit = 1'b1;
                break;
            end
            cur = nxt;
            moves++;
        end
        r.source_cell      = cur;
        r.source_global_id = no_data;
        if (on_grid(cur) && mapped.exists(int'(cur))) begin
            r.source_global_id = gid[int'(cur)];
            r.id_found         = 1'b1;
        end
        return r;
    endfunction

    task automatic flag(string what);
        errors++;
        $display("%0t ns: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            inflow.delete();
            discharge.delete();
            gid.delete();
            mapped.delete();
            pending_sources.delete();
            no_data  = NO_DATA_RESET;
            step_cap = MAX_STEPS_RESET;
        end else begin
            if (i_result_valid) begin
                if (pending_sources.size() == 0) begin
                    flag($sformatf("result word with no trace waiting, source cell %0d",
                                   i_result.source_cell));
                end else begin
                    want = pending_sources.pop_front();
                    if (i_result.source_cell !== want.source_cell)
                        flag($sformatf("source cell %0d, expected %0d",
                                       i_result.source_cell, want.source_cell));
                    if (i_result.source_global_id !== want.source_global_id)
                        flag($sformatf("global id %0d, expected %0d",
                                       i_result.source_global_id, want.source_global_id));
                    if (i_result.id_found !== want.id_found)
                        flag($sformatf("id found %b, expected %b",
                                       i_result.id_found, want.id_found));
                    if (i_result.step_limit_hit !== want.step_limit_hit)
                        flag($sformatf("step limit %b, expected %b",
                                       i_result.step_limit_hit, want.step_limit_hit));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_NO_DATA) no_data = i_cfg_wdata;
                else if (i_cfg_idx == REG_MAX_STEPS) step_cap = i_cfg_wdata[15:0];
            end
            if (i_start && !i_busy) begin
                case (i_item.command)
                    CMD_WR_NB: begin
                        if (on_grid(i_item.cell_req) && int'(i_item.slot) < SLOTS)
                            inflow[(int'(i_item.cell_req) - 1) * SLOTS + int'(i_item.slot)]
                                = i_item.neighbor_cell;
                    end
                    CMD_WR_DIS: begin
                        if (on_grid(i_item.cell_req))
                            discharge[int'(i_item.cell_req)] = i_item.discharge_value;
                    end
                    CMD_WR_GID: begin
                        if (on_grid(i_item.cell_req)) begin
                            gid[int'(i_item.cell_req)]    = i_item.global_value;
                            mapped[int'(i_item.cell_req)] = 1'b1;
                        end
                    end
                    default: pending_sources.push_back(trace_source(i_item.cell_req));
                endcase
            end
        end
        o_pending <= pending_sources.size();
    end

endmodule

>>> sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import umdt_pkg::*;

    localparam int LIMIT = 4_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 busy;
    t_item                item      = '0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 res_valid;
    t_result              res;
    int                   errors;
    int                   pending;
    int                   cycles     = 0;
    int                   words_sent = 0;
    int                   burst_left = 0;
    logic [15:0]          pool[$];
    bit                   taken[int];

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[upstream_max_discharge_trace_top] ERROR");
            $finish;
        end
    end

    upstream_max_discharge_trace_top uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (item),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    umdt_scoreboard u_sb (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .i_result_valid (res_valid),
        .i_result       (res),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 40);
            return 0;
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    function automatic logic [31:0] pick_discharge();
        case ($urandom_range(0, 7))
            0, 1:    return 32'd0;
            2, 3:    return 32'($urandom_range(1, 3));
            4:       return 32'hFFFF_FFFF;
            5:       return 32'($urandom_range(1, 3)) << 16;
            default: return $urandom;
        endcase
    endfunction

    // acyclic mode only points at cells ranked below; loop mode anywhere, self too
    function automatic logic [15:0] pick_inflow(int below, bit loops, logic [15:0] self);
        if (loops) begin
            if (pool.size() == 0 || $urandom_range(0, 6) == 0) return self;
            return pool[$urandom_range(0, pool.size() - 1)];
        end
        if (below == 0) return 16'd0;
        return pool[$urandom_range(0, below - 1)];
    endfunction

    function automatic t_item rand_word(t_cmd cmd, logic [15:0] c);
        t_item w;
        w.command         = cmd;
        w.cell_req        = c;
        w.slot            = 4'($urandom);
        w.neighbor_cell   = 16'($urandom);
        w.discharge_value = $urandom;
        w.global_value    = $urandom;
        return w;
    endfunction

    task automatic send_word(t_item w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_nb(logic [15:0] c, logic [3:0] s, logic [15:0] n);
        t_item w;
        w               = rand_word(CMD_WR_NB, c);
        w.slot          = s;
        w.neighbor_cell = n;
        send_word(w);
    endtask

    task automatic send_dis(logic [15:0] c, logic [31:0] d);
        t_item w;
        w                 = rand_word(CMD_WR_DIS, c);
        w.discharge_value = d;
        send_word(w);
    endtask

    task automatic send_gid(logic [15:0] c, logic [31:0] g);
        t_item w;
        w              = rand_word(CMD_WR_GID, c);
        w.global_value = g;
        send_word(w);
    endtask

    task automatic send_trace(logic [15:0] c);
        send_word(rand_word(CMD_TRACE, c));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
    endtask

    task automatic reconfigure(logic [31:0] nd, logic [15:0] steps);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_NO_DATA;
        cfg_wdata <= nd;
        @(posedge clk);
        cfg_idx   <= REG_MAX_STEPS;
        cfg_wdata <= {16'($urandom), steps};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(int quota, bit loops);
        int          stop;
        int          r;
        int          i;
        int          k;
        int          first;
        bit          dis_first;
        logic [15:0] c;
        logic [15:0] n;
        logic [15:0] inflows[9];
        pool.delete();
        taken.delete();
        stop = words_sent + quota;
        while (words_sent < stop) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) == 0) drain();
            if (pool.size() < 3 || (r < 8 && pool.size() < 24)) begin
                // every slot and the discharge land before any walk can reach the cell
                do begin
                    case ($urandom_range(0, 19))
                        0:       c = 16'd1;
                        1:       c = 16'hFFFF;
                        default: c = 16'($urandom_range(1, 65535));
                    endcase
                end while (taken.exists(int'(c)));
                taken[int'(c)] = 1'b1;
                case ($urandom_range(0, 9))
                    0, 1:    k = 0;
                    2, 3, 4: k = 1;
                    5, 6, 7: k = $urandom_range(2, 3);
                    default: k = $urandom_range(4, 9);
                endcase
                for (int j = 0; j < 9; j++) inflows[j] = 16'd0;
                for (int j = 0; j < k; j++)
                    inflows[$urandom_range(0, 8)] = pick_inflow(pool.size(), loops, c);
                first     = $urandom_range(0, 8);
                dis_first = $urandom_range(0, 1);
                if (dis_first) send_dis(c, pick_discharge());
                for (int j = 0; j < 9; j++)
                    send_nb(c, 4'((first + j) % 9), inflows[(first + j) % 9]);
                if (!dis_first) send_dis(c, pick_discharge());
                if ($urandom_range(0, 9) < 7) send_gid(c, $urandom);
                pool.push_back(c);
            end else if (r < 60) begin
                if ($urandom_range(0, 49) == 0) send_trace(16'd0);
                else send_trace(pool[$urandom_range(0, pool.size() - 1)]);
            end else if (r < 85) begin
                i = $urandom_range(0, pool.size() - 1);
                c = pool[i];
                case ($urandom_range(0, 2))
                    0: begin
                        n = ($urandom_range(0, 3) == 0) ? 16'd0 : pick_inflow(i, loops, c);
                        send_nb(c, 4'($urandom_range(0, 8)), n);
                    end
                    1:       send_dis(c, pick_discharge());
                    default: send_gid(c, $urandom);
                endcase
            end else begin
                // writes that land outside the traced cells or get dropped
                c = 16'($urandom_range(1, 65535));
                if (taken.exists(int'(c)) || $urandom_range(0, 3) == 0) c = 16'd0;
                case ($urandom_range(0, 3))
                    0: send_nb(pool[$urandom_range(0, pool.size() - 1)],
                               4'($urandom_range(9, 15)), 16'($urandom));
                    1:       send_nb(c, 4'($urandom_range(0, 8)), 16'($urandom));
                    2:       send_dis(c, $urandom);
                    default: send_gid(c, $urandom);
                endcase
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // out of range cell
        send_gid(16'd0, 32'h0000_1234);
        send_dis(16'd0, 32'hFFFF_FFFF);
        send_nb(16'd0, 4'd0, 16'hFFFF);
        send_trace(16'd0);
        // top cell as a source, slot writes above the last slot dropped
        for (int s = 0; s < SLOTS; s++) send_nb(16'hFFFF, 4'(s), 16'd0);
        send_nb(16'hFFFF, 4'd15, 16'd1);
        send_nb(16'hFFFF, 4'd9, 16'd1);
        send_trace(16'hFFFF);
        send_gid(16'hFFFF, 32'h7FFF_FFFF);
        send_trace(16'hFFFF);
        send_gid(16'hFFFF, 32'h8000_0000);
        send_trace(16'hFFFF);

        run_phase(130, 1'b0);
        reconfigure(32'h8000_0000, 16'd1);
        run_phase(130, 1'b1);
        reconfigure(32'h7FFF_FFFF, 16'hFFFF);
        run_phase(130, 1'b0);
        reconfigure($urandom, 16'($urandom_range(2, 40)));
        run_phase(130, 1'b1);
        reconfigure(32'd0, 16'($urandom_range(2, 8)));
        run_phase(130, 1'b0);
        reconfigure($urandom, 16'($urandom_range(9, 40)));
        run_phase(130, 1'b1);

        drain();
        repeat (64) @(posedge clk);
        if (errors == 0) begin
            $display("[upstream_max_discharge_trace_top] OK");
        end else begin
            $display("[upstream_max_discharge_trace_top] ERROR");
        end
        $finish;
    end

endmodule
